/* hdl/nks_pkg.sv */
// Shared types, register indexes and constants for the top-N kinematic selector.
package nks_pkg;

  // Default parameter values
  localparam int MAX_KEEP_DEF = 16;
  localparam int KEY_BITS_DEF = 32;
  localparam int ID_BITS_DEF  = 16;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 5;
  localparam logic [CFG_INDEX_W-1:0] REG_SORT_KEY   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEEP_COUNT = 1'd1;

  localparam int SORT_KEY_W   = 2;
  localparam int KEEP_COUNT_W = 5;

  // Ranking variable codes
  localparam logic [SORT_KEY_W-1:0] KEY_TRANS  = 2'd0;
  localparam logic [SORT_KEY_W-1:0] KEY_MOM    = 2'd1;
  localparam logic [SORT_KEY_W-1:0] KEY_ENERGY = 2'd2;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_CW    = 2;

  typedef struct packed {
    logic [31:0] trans_mom;
    logic [31:0] total_mom;
    logic [31:0] energy_val;
    logic [15:0] particle_id;
    logic        last_item;
  } in_word_t;

  typedef struct packed {
    logic [15:0] best_id;
    logic [31:0] best_value;
    logic [3:0]  rank_pos;
    logic        last_result;
  } out_word_t;

endpackage

/* hdl/nks_front.sv */
// Front end: accepts particle words, picks the ranking key, queues them for the back end.
module nks_front #(
  parameter int KEY_BITS = 32,
  parameter int ID_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  nks_pkg::in_word_t           in_data,
  input  logic [nks_pkg::SORT_KEY_W-1:0] sort_key,
  output logic                        q_valid,
  input  logic                        q_ready,
  output logic [KEY_BITS-1:0]         q_key,
  output logic [ID_BITS-1:0]          q_id,
  output logic                        q_last
);
  import nks_pkg::*;

  logic [KEY_BITS-1:0] qk [QUEUE_DEPTH];
  logic [ID_BITS-1:0]  qi [QUEUE_DEPTH];
  logic                ql [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] fill;
  logic [31:0]         sel_key;
  logic                push;
  logic                pop;

  always_comb begin
    case (sort_key)
      KEY_TRANS:  sel_key = in_data.trans_mom;
      KEY_MOM:    sel_key = in_data.total_mom;
      KEY_ENERGY: sel_key = in_data.energy_val;
      default:    sel_key = '0;  // no ranking variable: every item ties
    endcase
  end

  assign in_ready = (fill != QUEUE_CW'(QUEUE_DEPTH));
  assign q_valid  = (fill != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  assign q_key  = qk[rd_ptr];
  assign q_id   = qi[rd_ptr];
  assign q_last = ql[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      qk[wr_ptr] <= KEY_BITS'(sel_key);
      qi[wr_ptr] <= ID_BITS'(in_data.particle_id);
      ql[wr_ptr] <= in_data.last_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue fill above depth");

  a_fill_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (fill == $past(fill) + 1'b1))
    else $error("queue fill did not track push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with pointers apart");

endmodule

/* hdl/nks_back.sv */
// Back end: compare-and-shift insertion cells and the result sequencer.
module nks_back #(
  parameter int MAX_KEEP = 16,
  parameter int KEY_BITS = 32,
  parameter int ID_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [nks_pkg::KEEP_COUNT_W-1:0] keep_count,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  logic [KEY_BITS-1:0]             q_key,
  input  logic [ID_BITS-1:0]              q_id,
  input  logic                            q_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output nks_pkg::out_word_t              out_data
);
  import nks_pkg::*;

  localparam int CW = $clog2(MAX_KEEP + 1);
  localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  logic [KEY_BITS-1:0] vals [MAX_KEEP];
  logic [ID_BITS-1:0]  ids  [MAX_KEEP];
  logic [CW-1:0]       count;
  logic                emitting;
  logic [IW-1:0]       ei;
  logic [CW-1:0]       n_emit;

  logic [CW-1:0]       lim;
  logic [MAX_KEEP-1:0] gt;
  logic                drop;
  logic                pop;
  logic                ins;
  logic [CW-1:0]       cnt_after;
  logic [CW-1:0]       n_next;
  logic                load;
  logic                load_last;

  always_comb begin
    if (keep_count == '0) begin
      lim = CW'(1);
    end else if (32'(keep_count) > 32'(MAX_KEEP)) begin
      lim = CW'(MAX_KEEP);
    end else begin
      lim = CW'(keep_count);
    end
  end

  // gt is a run of ones from cell 0: the new key lands just past it
  always_comb begin
    drop = 1'b0;
    for (int p = 0; p < MAX_KEEP; p++) begin
      gt[p] = (CW'(p) < count) && (CW'(p) < lim) && (vals[p] > q_key);
      if (CW'(p) == lim - CW'(1)) drop = gt[p];
    end
  end

  assign q_ready = !emitting;
  assign pop     = q_valid && q_ready;
  assign ins     = pop && !drop;

  always_comb begin
    if (ins) begin
      cnt_after = (count < lim) ? count + CW'(1) : lim;
    end else begin
      cnt_after = count;
    end
    n_next = (cnt_after > lim) ? lim : cnt_after;
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      for (int p = 0; p < MAX_KEEP; p++) begin
        if (!gt[p]) begin
          if (p == 0 || gt[(p > 0) ? p - 1 : 0]) begin
            vals[p] <= q_key;
            ids[p]  <= q_id;
          end else begin
            vals[p] <= vals[(p > 0) ? p - 1 : 0];
            ids[p]  <= ids[(p > 0) ? p - 1 : 0];
          end
        end
      end
    end
  end

  assign load      = emitting && (!out_valid || out_ready);
  assign load_last = (CW'(ei) == n_emit - CW'(1));

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.best_id     <= 16'(ids[ei]);
      out_data.best_value  <= 32'(vals[ei]);
      out_data.rank_pos    <= 4'(ei);
      out_data.last_result <= load_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      emitting  <= 1'b0;
      ei        <= '0;
      n_emit    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (pop) begin
        count <= cnt_after;
        if (q_last) begin
          ei     <= '0;
          n_emit <= n_next;
          if (n_next == '0) begin
            count <= '0;
          end else begin
            emitting <= 1'b1;
          end
        end
      end else if (load) begin
        ei <= ei + 1'b1;
        if (load_last) begin
          emitting <= 1'b0;
          count    <= '0;
        end
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_KEEP))
    else $error("kept count above capacity");

  a_emit_index: assert property (@(posedge clk) disable iff (rst)
    emitting |-> (CW'(ei) < n_emit))
    else $error("emit index past list end");

  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    (load && load_last) |=> (!emitting && count == '0 && out_valid))
    else $error("list not cleared after final word");

endmodule

/* hdl/top_n_kinematic_select.sv */
// Top level of the top-N kinematic selector: config registers, front end, queue, back end.
//
//  channel   dir  handshake              payload
//  in        in   in_valid / in_ready    in_data  (in_word_t)
//  out       out  out_valid / out_ready  out_data (out_word_t)
//  cfg       in   cfg_we                 cfg_index, cfg_data
//
// One particle word per cycle enters while the queue has room; the insertion cells take
// one queued word a cycle while no list is being emitted. A last word makes the back
// end emit n kept words, one per cycle while out_ready holds; n is the kept count capped
// at keep_count clamped to 1..MAX_KEEP; the queue stalls as the sequencer walks the cells.
// Reset is synchronous; it empties the queue and the kept list.
// Output stalls hold the result register and backpressure through the queue.
module top_n_kinematic_select #(
  parameter int MAX_KEEP = nks_pkg::MAX_KEEP_DEF,
  parameter int KEY_BITS = nks_pkg::KEY_BITS_DEF,
  parameter int ID_BITS  = nks_pkg::ID_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  nks_pkg::in_word_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output nks_pkg::out_word_t              out_data,
  input  logic                            cfg_we,
  input  logic [nks_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [nks_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import nks_pkg::*;

  logic [SORT_KEY_W-1:0]   sort_key;
  logic [KEEP_COUNT_W-1:0] keep_count;

  logic                q_valid;
  logic                q_ready;
  logic [KEY_BITS-1:0] q_key;
  logic [ID_BITS-1:0]  q_id;
  logic                q_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_key   <= KEY_TRANS;
      keep_count <= KEEP_COUNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SORT_KEY:   sort_key   <= cfg_data[SORT_KEY_W-1:0];
        REG_KEEP_COUNT: keep_count <= cfg_data[KEEP_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  nks_front #(
    .KEY_BITS (KEY_BITS),
    .ID_BITS  (ID_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .sort_key (sort_key),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_key    (q_key),
    .q_id     (q_id),
    .q_last   (q_last)
  );

  nks_back #(
    .MAX_KEEP (MAX_KEEP),
    .KEY_BITS (KEY_BITS),
    .ID_BITS  (ID_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .keep_count (keep_count),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_key      (q_key),
    .q_id       (q_id),
    .q_last     (q_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

/* bench/top_n_kinematic_select_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the top-N kinematic selector: directed lists, then random lists.
module top_n_kinematic_select_tb;
  import nks_pkg::*;

  localparam int MAX_KEEP = MAX_KEEP_DEF;
  localparam int HOLD_OFF = 16;  // queue plus insertion cells, with margin
  localparam logic [SORT_KEY_W-1:0] KEY_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  top_n_kinematic_select dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // register mirror and kept list of the predictor
  logic [SORT_KEY_W-1:0] sort_sel = KEY_TRANS;
  logic [KEEP_COUNT_W-1:0] keep_sel = 5'd1;
  logic [31:0] kept_val [MAX_KEEP];
  logic [15:0] kept_pid [MAX_KEEP];
  int kept_n = 0;

  out_word_t ranked_q [$];
  in_word_t particle_txq [$];
  out_word_t want;

  int errors = 0;
  int taken_count = 0;
  int in_gap = 0;
  int out_stall = 0;
  int gap_draw;
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  bit calm = 1'b0;

  function automatic int pick_gap();
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic int keep_limit();
    if (keep_sel < 1) return 1;
    if (keep_sel > MAX_KEEP) return MAX_KEEP;
    return keep_sel;
  endfunction

  task automatic rank_particle(in_word_t w);
    logic [31:0] key;
    int lim, cnt, pos, j, n;
    out_word_t r;
    case (sort_sel)
      KEY_TRANS:  key = w.trans_mom;
      KEY_MOM:    key = w.total_mom;
      KEY_ENERGY: key = w.energy_val;
      default:    key = '0;
    endcase
    lim = keep_limit();
    cnt = (kept_n > MAX_KEEP) ? MAX_KEEP : kept_n;
    pos = 0;
    // newer word goes ahead of equal keys
    while (pos < cnt && pos < lim && kept_val[pos] > key) pos++;
    if (pos < lim) begin
      j = (cnt < lim) ? cnt : lim - 1;
      while (j > pos) begin
        kept_val[j] = kept_val[j-1];
        kept_pid[j] = kept_pid[j-1];
        j--;
      end
      kept_val[pos] = key;
      kept_pid[pos] = w.particle_id;
      kept_n = (cnt + 1 < lim) ? cnt + 1 : lim;
    end
    if (w.last_item) begin
      n = (kept_n > lim) ? lim : kept_n;
      for (int k = 0; k < n; k++) begin
        r.best_id = kept_pid[k];
        r.best_value = kept_val[k];
        r.rank_pos = 4'(k);
        r.last_result = (k == n - 1);
        ranked_q = {ranked_q, r};
      end
      kept_n = 0;
    end
  endtask

  // input side: sample at rising edge, drive at falling edge
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      rank_particle(in_data);
      taken_count <= taken_count + 1;
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (particle_txq.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= particle_txq.pop_front();
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side
  always @(negedge clk) begin
    if (out_taken) begin
      gap_draw = pick_gap();
      if (gap_draw == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        out_stall <= gap_draw - 1;
      end
    end else if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      out_taken <= 1'b1;
      if (ranked_q.size() == 0) begin
        $display("%0t: unexpected word id %h value %h rank %0d", $time,
                 out_data.best_id, out_data.best_value, out_data.rank_pos);
        errors++;
      end else begin
        want = ranked_q.pop_front();
        if (out_data.best_id !== want.best_id) begin
          $display("%0t: best_id expected %h actual %h", $time, want.best_id,
                   out_data.best_id);
          errors++;
        end
        if (out_data.best_value !== want.best_value) begin
          $display("%0t: best_value expected %h actual %h", $time, want.best_value,
                   out_data.best_value);
          errors++;
        end
        if (out_data.rank_pos !== want.rank_pos) begin
          $display("%0t: rank_pos expected %0d actual %0d", $time, want.rank_pos,
                   out_data.rank_pos);
          errors++;
        end
        if (out_data.last_result !== want.last_result) begin
          $display("%0t: last_result expected %b actual %b", $time, want.last_result,
                   out_data.last_result);
          errors++;
        end
      end
    end else begin
      out_taken <= 1'b0;
    end
  end

  task automatic send_particle(in_word_t w);
    int target;
    target = taken_count + 1;
    particle_txq = {particle_txq, w};
    wait (taken_count >= target);
  endtask

  task automatic wait_idle();
    while (particle_txq.size() != 0 || in_valid || ranked_q.size() != 0) @(posedge clk);
  endtask

  task automatic settle(int n);
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SORT_KEY:   sort_sel = val[SORT_KEY_W-1:0];
      REG_KEEP_COUNT: keep_sel = val;
      default: ;
    endcase
  endtask

  function automatic in_word_t particle(logic [31:0] tm, logic [31:0] mo, logic [31:0] en,
                                        logic [15:0] id, logic last);
    in_word_t w;
    w.trans_mom = tm;
    w.total_mom = mo;
    w.energy_val = en;
    w.particle_id = id;
    w.last_item = last;
    return w;
  endfunction

  // mix of ties, extremes and full-range magnitudes
  function automatic logic [31:0] rand_mag();
    case ($urandom_range(0, 7))
      0, 1:    return 32'($urandom_range(0, 7));
      2:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_word_t random_particle(logic last);
    return particle(rand_mag(), rand_mag(), rand_mag(), 16'($urandom), last);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_key_word();
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'($urandom);
    v[SORT_KEY_W-1:0] = SORT_KEY_W'($urandom_range(0, 3));
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_keep_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_DATA_W'($urandom_range(17, 31));
      2:       return CFG_DATA_W'(MAX_KEEP);
      default: return CFG_DATA_W'($urandom_range(1, MAX_KEEP));
    endcase
  endfunction

  // reset values: key is trans_mom, keep one; equal keys keep the newest
  task automatic test_reset_state();
    send_particle(particle(32'd5, 32'd90, 32'd90, 16'h0001, 1'b0));
    send_particle(particle(32'd9, 32'd1, 32'd1, 16'h0002, 1'b0));
    send_particle(particle(32'd9, 32'd0, 32'd0, 16'h0003, 1'b1));
    wait_idle();
  endtask

  task automatic test_trans_extremes();
    write_reg(REG_KEEP_COUNT, CFG_DATA_W'(MAX_KEEP));
    send_particle(particle(32'hFFFF_FFFF, 32'h0, 32'h0, 16'hFFFF, 1'b0));
    send_particle(particle(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 1'b0));
    send_particle(particle(32'h7, 32'hAAAA_AAAA, 32'h5555_5555, 16'h5555, 1'b0));
    send_particle(particle(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA, 1'b0));
    send_particle(particle(32'h0, 32'h1, 32'h2, 16'h1234, 1'b1));
    wait_idle();
  endtask

  task automatic test_each_key();
    logic [SORT_KEY_W-1:0] keys [3];
    keys = '{KEY_MOM, KEY_ENERGY, KEY_NONE};
    write_reg(REG_KEEP_COUNT, 5'd4);
    foreach (keys[i]) begin
      write_reg(REG_SORT_KEY, {3'b111, keys[i]});
      send_particle(particle(32'd100, 32'd10, 32'd20, 16'h0A00 + 16'(i), 1'b0));
      send_particle(particle(32'd1, 32'd30, 32'd5, 16'h0B00 + 16'(i), 1'b1));
      wait_idle();
    end
    write_reg(REG_SORT_KEY, {3'b000, KEY_TRANS});
  endtask

  // zero keeps one, above the table keeps the table size
  task automatic test_keep_bounds();
    write_reg(REG_KEEP_COUNT, 5'd0);
    send_particle(particle(32'd100, 32'd0, 32'd0, 16'h00C1, 1'b0));
    send_particle(particle(32'd200, 32'd0, 32'd0, 16'h00C2, 1'b1));
    wait_idle();
    write_reg(REG_KEEP_COUNT, 5'd31);
    send_particle(particle(32'd3, 32'd0, 32'd0, 16'h00D1, 1'b0));
    send_particle(particle(32'd8, 32'd0, 32'd0, 16'h00D2, 1'b0));
    send_particle(particle(32'd5, 32'd0, 32'd0, 16'h00D3, 1'b1));
    wait_idle();
  endtask

  // keep count cut while a list is half built
  task automatic test_keep_lowered();
    write_reg(REG_KEEP_COUNT, 5'd8);
    send_particle(particle(32'd40, 32'd0, 32'd0, 16'h0E01, 1'b0));
    send_particle(particle(32'd10, 32'd0, 32'd0, 16'h0E02, 1'b0));
    send_particle(particle(32'd30, 32'd0, 32'd0, 16'h0E03, 1'b0));
    send_particle(particle(32'd20, 32'd0, 32'd0, 16'h0E04, 1'b0));
    wait_idle();
    settle(HOLD_OFF);
    write_reg(REG_KEEP_COUNT, 5'd2);
    send_particle(particle(32'd25, 32'd0, 32'd0, 16'h0E05, 1'b1));
    wait_idle();
  endtask

  task automatic test_random_lists(int n_items);
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) == 0) write_reg(REG_SORT_KEY, random_key_word());
      if ($urandom_range(0, 1) == 0) write_reg(REG_KEEP_COUNT, random_keep_word());
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        if (i > 0 && $urandom_range(0, 15) == 0) begin
          // sender holds off mid-list so a register can change
          wait_idle();
          settle(HOLD_OFF);
          if ($urandom_range(0, 2) == 0) write_reg(REG_SORT_KEY, random_key_word());
          else write_reg(REG_KEEP_COUNT, random_keep_word());
        end
        send_particle(random_particle(i == len - 1));
        sent++;
      end
      wait_idle();
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_trans_extremes();
    test_each_key();
    test_keep_bounds();
    test_keep_lowered();
    test_random_lists(450);
    wait_idle();
    settle(40);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
